// File: sv/rplm_pkg.sv
// Package: widths, register indexes and saturating adders for the loss monitor.
`timescale 1ns / 1ps
`default_nettype none

package rplm_pkg;

  localparam int SEQ_W     = 16;
  localparam int TS_W      = 32;
  localparam int ILEN_W    = 14;
  localparam int PERIOD_W  = 32;
  localparam int CNT_W     = 16;
  localparam int PER_W     = 32;
  localparam int CUM_W     = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD   = 1'b1;

  localparam logic [ILEN_W-1:0]   ILEN_RESET   = 14'd10;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd450000;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [PER_W-1:0] per_t;
  typedef logic [CUM_W-1:0] cum_t;

  function automatic cnt_t sat_inc16(input cnt_t a);
    sat_inc16 = (a == '1) ? a : a + 1'b1;
  endfunction

  function automatic per_t sat_add32(input per_t a, input per_t b);
    logic [PER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add32 = s[PER_W] ? '1 : s[PER_W-1:0];
  endfunction

  function automatic cum_t sat_add48(input cum_t a, input per_t b);
    logic [CUM_W:0] s;
    s = {1'b0, a} + {{(CUM_W-PER_W+1){1'b0}}, b};
    sat_add48 = s[CUM_W] ? '1 : s[CUM_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/rplm_in_if.sv
// Packet request channel: sequence number and timestamp with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface rplm_in_if import rplm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    seq_number;
  logic [TS_W-1:0]     media_timestamp;

  modport source (output valid, output seq_number, output media_timestamp, input ready);
  modport sink   (input valid, input seq_number, input media_timestamp, output ready);
endinterface

`default_nettype wire

// File: sv/rplm_out_if.sv
// Result channel: report flag, last-period and cumulative totals with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface rplm_out_if import rplm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       report_now;
  per_t       received_last;
  per_t       expected_last;
  cum_t       received_total;
  cum_t       expected_total;

  modport source (output valid, output report_now, output received_last,
                  output expected_last, output received_total, output expected_total,
                  input ready);
  modport sink   (input valid, input report_now, input received_last,
                  input expected_last, input received_total, input expected_total,
                  output ready);
endinterface

`default_nettype wire

// File: sv/rtp_packet_loss_monitor_top.sv
// Top level: RTP packet loss monitor, window counters and periodic loss report.
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-------------------------------------------
//   in_if    | in  | valid/ready        | seq_number[15:0], media_timestamp[31:0]
//   out_if   | out | valid/ready        | report_now, received/expected_last[31:0],
//            |     |                    | received/expected_total[47:0]
//   cfg_*    | in  | cfg_we             | cfg_index (0 interval, 1 period), cfg_data
//
// One request per cycle while the result slot is free or draining; a request passes the
// input register, then update logic into the state and result registers.
// The state update is one pass per request: a 16-bit distance compare, a 32-bit saturating
// add into the period totals on a slide, then a 48-bit one into the totals on a report.
// Reset (rst_n low, synchronous) clears all counters and restores the register defaults.
// A stalled result holds; input keeps flowing while the result slot is free or draining.
`timescale 1ns / 1ps
`default_nettype none

module rtp_packet_loss_monitor_top import rplm_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  rplm_in_if.sink              in_if,
  rplm_out_if.source           out_if
);

  // config
  logic [ILEN_W-1:0]   ilen_r;
  logic [PERIOD_W-1:0] period_r;

  // input register
  logic             s0_valid_r;
  logic [SEQ_W-1:0] s0_seq_r;
  logic [TS_W-1:0]  s0_ts_r;

  // monitor state
  logic             win_valid_r;
  logic [SEQ_W-1:0] win_start_r;
  cnt_t             near_r;
  cnt_t             far_r;
  per_t             per_rcv_r;
  per_t             per_exp_r;
  cum_t             cum_rcv_r;
  cum_t             cum_exp_r;
  per_t             lat_rcv_r;
  per_t             lat_exp_r;
  logic [TS_W-1:0]  per_start_r;

  // result register (totals are read straight from the state)
  logic             out_valid_r;
  logic             report_r;

  logic             advance;
  logic             in_take;

  // next-state values
  logic             win_valid_nxt;
  logic [SEQ_W-1:0] win_start_nxt;
  cnt_t             near_nxt;
  cnt_t             far_nxt;
  per_t             per_rcv_nxt;
  per_t             per_exp_nxt;
  cum_t             cum_rcv_nxt;
  cum_t             cum_exp_nxt;
  per_t             lat_rcv_nxt;
  per_t             lat_exp_nxt;
  logic [TS_W-1:0]  per_start_nxt;
  logic             report_nxt;

  // window placement
  logic [SEQ_W-1:0] seq_dist;
  logic [SEQ_W-1:0] ilen_ext;
  logic [SEQ_W-1:0] ilen_x2;
  per_t             per_rcv_upd;
  per_t             per_exp_upd;
  logic [TS_W-1:0]  elapsed;

  // process when the result slot is free or draining this cycle
  assign advance     = s0_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s0_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  assign ilen_ext = {{(SEQ_W-ILEN_W){1'b0}}, ilen_r};
  assign ilen_x2  = {{(SEQ_W-ILEN_W-1){1'b0}}, ilen_r, 1'b0};
  assign seq_dist = s0_seq_r - win_start_r;
  assign elapsed  = s0_ts_r - per_start_r;

  always_comb begin
    win_valid_nxt = 1'b1;
    win_start_nxt = win_start_r;
    near_nxt      = near_r;
    far_nxt       = far_r;
    per_rcv_upd   = per_rcv_r;
    per_exp_upd   = per_exp_r;

    if (!win_valid_r) begin
      // first packet anchors the window
      win_start_nxt = s0_seq_r;
      near_nxt      = sat_inc16(near_r);
    end else if (seq_dist < ilen_x2) begin
      if (seq_dist < ilen_ext) begin
        near_nxt = sat_inc16(near_r);
      end else begin
        far_nxt = sat_inc16(far_r);
      end
    end else begin
      // beyond both intervals: close near, slide by one interval
      per_rcv_upd   = sat_add32(per_rcv_r, {{(PER_W-CNT_W){1'b0}}, near_r});
      per_exp_upd   = sat_add32(per_exp_r, {{(PER_W-ILEN_W){1'b0}}, ilen_r});
      win_start_nxt = win_start_r + ilen_ext;
      near_nxt      = far_r;
      far_nxt       = cnt_t'(1);
    end

    per_rcv_nxt   = per_rcv_upd;
    per_exp_nxt   = per_exp_upd;
    cum_rcv_nxt   = cum_rcv_r;
    cum_exp_nxt   = cum_exp_r;
    lat_rcv_nxt   = lat_rcv_r;
    lat_exp_nxt   = lat_exp_r;
    per_start_nxt = per_start_r;
    report_nxt    = 1'b0;

    if ((elapsed > period_r) && (per_exp_upd != '0)) begin
      cum_rcv_nxt   = sat_add48(cum_rcv_r, per_rcv_upd);
      cum_exp_nxt   = sat_add48(cum_exp_r, per_exp_upd);
      lat_rcv_nxt   = per_rcv_upd;
      lat_exp_nxt   = per_exp_upd;
      per_rcv_nxt   = '0;
      per_exp_nxt   = '0;
      per_start_nxt = s0_ts_r;
      report_nxt    = 1'b1;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ilen_r   <= ILEN_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL_LENGTH: ilen_r   <= cfg_data[ILEN_W-1:0];
        CFG_REPORT_PERIOD:   period_r <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s0_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_seq_r <= in_if.seq_number;
      s0_ts_r  <= in_if.media_timestamp;
    end
  end

  // monitor state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_valid_r <= 1'b0;
      win_start_r <= '0;
      near_r      <= '0;
      far_r       <= '0;
      per_rcv_r   <= '0;
      per_exp_r   <= '0;
      cum_rcv_r   <= '0;
      cum_exp_r   <= '0;
      lat_rcv_r   <= '0;
      lat_exp_r   <= '0;
      per_start_r <= '0;
      report_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        win_valid_r <= win_valid_nxt;
        win_start_r <= win_start_nxt;
        near_r      <= near_nxt;
        far_r       <= far_nxt;
        per_rcv_r   <= per_rcv_nxt;
        per_exp_r   <= per_exp_nxt;
        cum_rcv_r   <= cum_rcv_nxt;
        cum_exp_r   <= cum_exp_nxt;
        lat_rcv_r   <= lat_rcv_nxt;
        lat_exp_r   <= lat_exp_nxt;
        per_start_r <= per_start_nxt;
        report_r    <= report_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.report_now     = report_r;
  assign out_if.received_last  = lat_rcv_r;
  assign out_if.expected_last  = lat_exp_r;
  assign out_if.received_total = cum_rcv_r;
  assign out_if.expected_total = cum_exp_r;

endmodule

`default_nettype wire

// File: tb/sv/rtp_packet_loss_monitor_top_test.sv
// Testbench for the RTP packet loss monitor: directed, duplicate, pressure and random traffic.
`timescale 1ns / 1ps

module rtp_packet_loss_monitor_top_test;
  import rplm_pkg::*;

  // Run limits. The longest legal quiet stretch is the receiver hold-off plus the input
  // and result registers; the watchdog allows several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 8;
  localparam int DUP_REPEAT     = 40;

  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

  // One loss report, as the block returns it for every packet.
  typedef struct packed {
    logic report_now;
    per_t received_last;
    per_t expected_last;
    cum_t received_total;
    cum_t expected_total;
  } loss_report_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  rplm_in_if  in_ch ();
  rplm_out_if out_ch ();

  rtp_packet_loss_monitor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the register values and the window / period state.
  // ---------------------------------------------------------------------------
  logic [ILEN_W-1:0]   cfg_ilen;
  logic [PERIOD_W-1:0] cfg_period;

  logic        win_valid;
  logic [15:0] win_base;
  logic [15:0] near_cnt;
  logic [15:0] far_cnt;
  logic [31:0] per_recv;
  logic [31:0] per_exp;
  logic [47:0] tot_recv;
  logic [47:0] tot_exp;
  logic [31:0] last_recv;
  logic [31:0] last_exp;
  logic [31:0] per_start_ts;

  // Expected reports, oldest first, one per accepted packet request.
  loss_report_t pending_reports[$];

  // Saturating add, clipped at the given ceiling (all counters are at most 48 bits).
  function automatic logic [47:0] sat_sum(input logic [47:0] a, input logic [47:0] b,
                                          input logic [47:0] ceiling);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, ceiling}) ? ceiling : s[47:0];
  endfunction

  function automatic loss_report_t predict_report(input logic [15:0] seq,
                                                  input logic [31:0] ts);
    logic [15:0]  seq_dist;
    logic [16:0]  span;
    logic [31:0]  elapsed;
    loss_report_t r;
    r.report_now = 1'b0;
    if (!win_valid) begin
      // first packet anchors the window
      win_valid = 1'b1;
      win_base  = seq;
      near_cnt  = 16'(sat_sum(48'(near_cnt), 48'd1, 48'hFFFF));
    end else begin
      seq_dist = seq - win_base;
      span = {2'b00, cfg_ilen, 1'b0};
      if ({1'b0, seq_dist} < span) begin
        if (seq_dist < {2'b00, cfg_ilen})
          near_cnt = 16'(sat_sum(48'(near_cnt), 48'd1, 48'hFFFF));
        else
          far_cnt = 16'(sat_sum(48'(far_cnt), 48'd1, 48'hFFFF));
      end else begin
        // beyond both intervals: close the near one and slide the window
        per_recv = 32'(sat_sum(48'(per_recv), 48'(near_cnt), 48'hFFFF_FFFF));
        per_exp  = 32'(sat_sum(48'(per_exp), 48'(cfg_ilen), 48'hFFFF_FFFF));
        win_base = win_base + {2'b00, cfg_ilen};
        near_cnt = far_cnt;
        far_cnt  = 16'd1;
      end
    end
    elapsed = ts - per_start_ts;
    if (elapsed > cfg_period && per_exp != 32'd0) begin
      tot_recv     = sat_sum(tot_recv, 48'(per_recv), 48'hFFFF_FFFF_FFFF);
      tot_exp      = sat_sum(tot_exp, 48'(per_exp), 48'hFFFF_FFFF_FFFF);
      last_recv    = per_recv;
      last_exp     = per_exp;
      per_recv     = 32'd0;
      per_exp      = 32'd0;
      per_start_ts = ts;
      r.report_now = 1'b1;
    end
    r.received_last  = last_recv;
    r.expected_last  = last_exp;
    r.received_total = tot_recv;
    r.expected_total = tot_exp;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Shared bookkeeping and traffic shaping knobs.
  // ---------------------------------------------------------------------------
  int errors          = 0;
  int packets_sent    = 0;
  int results_checked = 0;
  int reports_seen    = 0;
  int config_count    = 0;
  int idle_cycles     = 0;

  bit       tx_bursty  = 1'b0;
  int       burst_left = 0;
  rx_mode_e rx_mode    = RX_ALWAYS;
  int       rx_pat_len = 5;
  int       rx_cyc     = 0;
  int       rx_hold_len = 0;

  logic [15:0] str_seq;
  logic [31:0] str_ts;

  // ---------------------------------------------------------------------------
  // Result side: stall pattern of its own, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (rx_hold_len != 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        case (rx_mode)
          RX_ALWAYS: out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default:   out_ch.ready <= ((rx_cyc % rx_pat_len) < (rx_pat_len - 2));
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (want !== got) begin
      $display("%0t ERROR %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Checker: every accepted result against the oldest expectation. Also feeds the
  // watchdog with the number of cycles in which neither channel moved a request.
  always @(posedge clk) begin
    loss_report_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, actual total %0h/%0h",
                 $time, out_ch.received_total, out_ch.expected_total);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("report_now",     48'(want.report_now),    48'(out_ch.report_now));
        check_field("received_last",  48'(want.received_last), 48'(out_ch.received_last));
        check_field("expected_last",  48'(want.expected_last), 48'(out_ch.expected_last));
        check_field("received_total", want.received_total, out_ch.received_total);
        check_field("expected_total", want.expected_total, out_ch.expected_total);
        results_checked++;
        if (out_ch.report_now === 1'b1) reports_seen++;
      end
    end
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t watchdog: no request moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Offer one packet request; in bursty mode a random gap opens between bursts.
  // Returns at the edge where the request was taken.
  task automatic send_packet(input logic [15:0] seq, input logic [31:0] ts);
    int gap;
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_ch.valid           <= 1'b1;
    in_ch.seq_number      <= seq;
    in_ch.media_timestamp <= ts;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_reports.push_back(predict_report(seq, ts));
    packets_sent++;
  endtask

  // Stop offering and wait until every expected report is back. Each packet gives
  // exactly one report, so an empty queue means nothing is left in the pipeline.
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_INTERVAL_LENGTH)
      cfg_ilen = value[ILEN_W-1:0];
    else
      cfg_period = value;
  endtask

  task automatic set_config(input logic [ILEN_W-1:0] ilen, input logic [PERIOD_W-1:0] period);
    drain_reports();
    write_reg(CFG_INTERVAL_LENGTH, {{(CFG_DATA_W-ILEN_W){1'b0}}, ilen});
    write_reg(CFG_REPORT_PERIOD, period);
    config_count++;
  endtask

  // Mostly an in-order stream with random losses, reordering and duplicates; some
  // noise packets jump anywhere in sequence and time.
  task automatic send_stream_packet();
    int          pick;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] step_max;
    step_max = (cfg_period >> 3) + 32'd2;
    str_ts = str_ts + $urandom_range(0, step_max);
    ts = str_ts;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      str_seq = str_seq + 16'd1;
      seq = str_seq;
    end else if (pick < 77) begin
      // loss burst, sometimes past both intervals
      str_seq = 16'(str_seq + 16'd1 + $urandom_range(1, 2 * cfg_ilen + 3));
      seq = str_seq;
    end else if (pick < 85) begin
      // late packet
      seq = 16'(str_seq - $urandom_range(1, 6));
      ts = str_ts - $urandom_range(0, step_max);
    end else if (pick < 90) begin
      seq = str_seq;
    end else if (pick < 96) begin
      str_seq = 16'($urandom);
      seq = str_seq;
    end else begin
      seq = 16'($urandom);
      ts = $urandom;
    end
    send_packet(seq, ts);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values of both registers; first packet against a period start of 0 with a
  // huge elapsed time but nothing expected; sequence wrap; near, far, close twice;
  // then a report on the fifth packet.
  task automatic test_reset_defaults();
    tx_bursty = 1'b1;
    rx_mode = RX_RANDOM;
    send_packet(16'hFFFF, 32'hFFFF_FFF0);
    send_packet(16'h0000, 32'hFFFF_FFF8);
    send_packet(16'h000A, 32'h0000_0004);
    send_packet(16'h0013, 32'h0000_000C);
    send_packet(16'h0000, 32'h0007_0000);
  endtask

  // Extremes of both input fields, with both registers at their largest values.
  task automatic test_field_extremes();
    set_config(14'h3FFF, 32'hFFFF_FFFF);
    send_packet(16'h0000, 32'h0000_0000);
    send_packet(16'hFFFF, 32'hFFFF_FFFF);
    send_packet(16'h5555, 32'h5555_5555);
    send_packet(16'hAAAA, 32'hAAAA_AAAA);
  endtask

  // Interval of 1, zero report period: any forward step in time reports if anything is expected.
  task automatic test_period_zero();
    logic [31:0] t0;
    set_config(14'd1, 32'd0);
    t0 = $urandom;
    send_packet(win_base, t0);
    send_packet(win_base + 16'd1, t0);
    send_packet(win_base + 16'd2, t0 + 32'd1);
    send_packet(win_base + 16'd2, t0 + 32'd1);
    send_packet(win_base + 16'd2, t0 + 32'd2);
  endtask

  // Elapsed time taken across the 32-bit timestamp wrap.
  task automatic test_timestamp_wrap();
    set_config(14'd2, 32'd100);
    send_packet(win_base + 16'd10, 32'hFFFF_FF00);
    send_packet(win_base + 16'd10, 32'h0000_0050);
    send_packet(win_base + 16'd10, 32'h0000_0060);
    send_packet(win_base + 16'd1,  32'h0000_0100);
  endtask

  // Zero interval: every packet closes, nothing is added to the expected count and
  // the window start stays put.
  task automatic test_zero_interval();
    set_config(14'd0, 32'd1000);
    send_packet(win_base, 32'd5000);
    send_packet(win_base + 16'd1, 32'd5600);
    send_packet(16'($urandom), 32'd6200);
    send_packet(win_base, 32'd6800);
  endtask

  // Near and far counters pumped with duplicates, then shifted out into the period
  // total. Back to back traffic keeps this part short.
  task automatic test_duplicate_counts();
    logic [15:0] base;
    logic [31:0] ts;
    set_config(14'd4, 32'hFFFF_FFFF);
    tx_bursty = 1'b0;
    rx_mode = RX_ALWAYS;
    base = win_base;
    ts = $urandom;
    repeat (DUP_REPEAT) send_packet(base, ts);
    repeat (DUP_REPEAT) send_packet(base + 16'd4, ts);
    send_packet(base + 16'd100, ts);
    send_packet(base + 16'd200, ts);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering, so the
  // block fills and stalls its input; then the sender pauses until all is back.
  task automatic test_backpressure();
    set_config(14'd8, 32'd5000);
    tx_bursty = 1'b0;
    rx_mode = RX_ALWAYS;
    str_seq = 16'($urandom);
    str_ts = $urandom;
    rx_hold_len = HOLD_CYCLES;
    repeat (60) send_stream_packet();
    drain_reports();
    tx_bursty = 1'b1;
    rx_mode = RX_RANDOM;
    repeat (20) send_stream_packet();
    drain_reports();
    repeat (20) send_stream_packet();
  endtask

  task automatic test_random_traffic();
    int phase;
    int n_items;
    for (phase = 0; phase < 7; phase++) begin
      case (phase)
        0: begin set_config(14'd10, 32'd30000); n_items = 250; end
        1: begin set_config(14'd1, 32'd0); n_items = 200; end
        2: begin set_config(14'h3FFF, 32'hFFFF_FFFF); n_items = 150; end
        3: begin set_config(14'd64, 32'd100000); n_items = 250; end
        4: begin
          set_config(14'($urandom_range(1, 400)), 32'($urandom_range(500, 200000)));
          n_items = 250;
        end
        5: begin set_config(14'($urandom_range(1, 16383)), $urandom); n_items = 200; end
        default: begin set_config(14'd3, 32'd2000); n_items = 200; end
      endcase
      // mix of idling styles; phases 2 and 6 run with no idling at all
      tx_bursty  = (phase % 3 != 2) && (phase != 6);
      rx_mode    = (phase == 2 || phase == 6) ? RX_ALWAYS :
                   (phase % 2 == 1) ? RX_PATTERN : RX_RANDOM;
      rx_pat_len = $urandom_range(4, 9);
      str_seq = 16'($urandom);
      str_ts = $urandom;
      repeat (n_items) send_stream_packet();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    // Predictor starts from the block's reset state.
    cfg_ilen     = ILEN_RESET;
    cfg_period   = PERIOD_RESET;
    win_valid    = 1'b0;
    win_base     = '0;
    near_cnt     = '0;
    far_cnt      = '0;
    per_recv     = '0;
    per_exp      = '0;
    tot_recv     = '0;
    tot_exp      = '0;
    last_recv    = '0;
    last_exp     = '0;
    per_start_ts = '0;

    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_index             <= CFG_INTERVAL_LENGTH;
    cfg_data              <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.seq_number      <= '0;
    in_ch.media_timestamp <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_field_extremes();
    test_period_zero();
    test_timestamp_wrap();
    test_zero_interval();
    test_duplicate_counts();
    test_backpressure();
    test_random_traffic();

    drain_reports();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run: %0d packet requests, %0d results checked, %0d period reports,",
             packets_sent, results_checked, reports_seen);
    $display("     %0d register settings incl. extremes, duplicate bursts, stalls, %0d errors",
             config_count, errors);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
